// File: rtl/lst_pkg.sv
// Shared types and constants for the lazy segment tree block.
// Used by lst_alu and the top level; no dependencies.
package lst_pkg;

  localparam int MaxElem    = 1024;
  localparam int NodeDepth  = 4 * MaxElem;
  localparam int ValW       = 64;
  localparam int PosW       = 11;
  localparam int NodeW      = $clog2(NodeDepth);
  localparam int ElemAW     = $clog2(MaxElem);
  localparam int StackDepth = 12;
  localparam int SpW        = $clog2(StackDepth + 1);

  typedef enum logic [1:0] {
    FUNC_LOAD,
    FUNC_BUILD,
    FUNC_ADD,
    FUNC_SUM
  } func_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_VISIT,
    S_ACC,
    S_AP0,
    S_AP1,
    S_BLF,
    S_HD0,
    S_HD1,
    S_HD2,
    S_HD3,
    S_HD4,
    S_HD5,
    S_RET,
    S_FIN0,
    S_FIN1,
    S_FIN2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [PosW-1:0]  lo;
    logic [PosW-1:0]  hi;
    logic             right;
  } frame_t;

  typedef struct packed {
    logic [ValW-1:0] add_a;
    logic [ValW-1:0] add_b;
    logic            mul_en;
    logic [ValW-1:0] mul_a;
    logic [PosW-1:0] mul_b;
  } alu_ctrl_t;

endpackage

// File: rtl/lst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lst_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lst_alu.sv
// Shared arithmetic unit: one 64-bit adder and a registered span multiplier.
// Depends on lst_pkg.
module lst_alu (
  input  logic                    clk,
  input  lst_pkg::alu_ctrl_t      ctrl,
  output logic [lst_pkg::ValW-1:0] add_y,
  output logic [lst_pkg::ValW-1:0] prod
);

  logic [lst_pkg::ValW-1:0] prod_r;

  assign add_y = ctrl.add_a + ctrl.add_b;

  // span is at most the element count, so the product is a narrow multiply
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= ctrl.mul_a * lst_pkg::ValW'(ctrl.mul_b);
    end
  end

  assign prod = prod_r;

endmodule

// File: rtl/lazy_segment_tree_range_add_sum.sv
// Lazy segment tree over up to 1024 signed 64-bit elements: load, build, range add and
// range sum. After reset the block sweeps its tag and sum memories and accepts no request
// meanwhile; a build sweeps the tag memory the same way, then walks the tree, loading each
// leaf from the element memory and summing the children of each inner node on the way back.
// A range add or sum walks the tree from the root with an explicit stack, visiting roughly
// 40 nodes at most for 1024 elements. The walk rate is set by the single read port of each
// memory and the one shared adder. Results sit in an output register, so a new request is
// taken while a sum waits to be read.
module lazy_segment_tree_range_add_sum (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_func,
  input  logic [lst_pkg::PosW-1:0]        in_position_left,
  input  logic [lst_pkg::PosW-1:0]        in_position_right,
  input  logic signed [lst_pkg::ValW-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [lst_pkg::ValW-1:0] out_range_sum,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lst_pkg::PosW-1:0]        cfg_data
);

  localparam int PosW  = lst_pkg::PosW;
  localparam int NodeW = lst_pkg::NodeW;
  localparam int ValW  = lst_pkg::ValW;
  localparam int SpW   = lst_pkg::SpW;

  lst_pkg::state_t state_r, state_nxt;
  lst_pkg::func_t  func_r, func_nxt;
  logic [NodeW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             clr_sums_r, clr_sums_nxt;
  logic [PosW-1:0]  cnt_r, cnt_nxt;
  logic [PosW-1:0]  l_r, l_nxt, r_r, r_nxt;
  logic [ValW-1:0]  inc_r, inc_nxt, acc_r, acc_nxt, t_r, t_nxt, s_tmp_r, s_tmp_nxt;
  logic [NodeW-1:0] cur_node_r, cur_node_nxt;
  logic [PosW-1:0]  cur_lo_r, cur_lo_nxt, cur_hi_r, cur_hi_nxt;
  logic [SpW-1:0]   sp_r, sp_nxt;
  lst_pkg::frame_t  stk_r [lst_pkg::StackDepth];
  lst_pkg::frame_t  stk_nxt [lst_pkg::StackDepth];
  logic             out_valid_r, out_valid_nxt;
  logic [ValW-1:0]  out_sum_r, out_sum_nxt;

  // memory ports
  logic                          s_we, p_we, e_we;
  logic [NodeW-1:0]              s_waddr, s_raddr, p_waddr, p_raddr;
  logic [ValW-1:0]               s_wdata, p_wdata, s_rd, p_rd, e_rd;
  logic [lst_pkg::ElemAW-1:0]    e_waddr, e_raddr;

  lst_pkg::alu_ctrl_t alu_ctrl;
  logic [ValW-1:0]    add_y, prod;

  // tree geometry of the current node and the stack top
  logic [PosW:0]    mid_sum, top_mid_sum;
  logic [PosW-1:0]  mid, top_mid, span, span_l, span_r, lo_m1, in_l_m1;
  logic [NodeW-1:0] lnode, rnode;
  logic [SpW-1:0]   sp_m1;
  lst_pkg::frame_t  top;
  logic             covered, disjoint, leaf, descend, accept, out_free, in_empty;
  logic [PosW-1:0]  in_l_clip, in_r_clip;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != lst_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign mid_sum  = {1'b0, cur_lo_r} + {1'b0, cur_hi_r};
  assign mid      = mid_sum[PosW:1];
  assign span     = cur_hi_r - cur_lo_r + PosW'(1);
  assign span_l   = mid - cur_lo_r + PosW'(1);
  assign span_r   = cur_hi_r - mid;
  assign lnode    = {cur_node_r[NodeW-2:0], 1'b0};
  assign rnode    = {cur_node_r[NodeW-2:0], 1'b1};
  assign lo_m1    = cur_lo_r - PosW'(1);
  assign sp_m1    = sp_r - SpW'(1);
  assign top      = stk_r[sp_m1];
  assign top_mid_sum = {1'b0, top.lo} + {1'b0, top.hi};
  assign top_mid  = top_mid_sum[PosW:1];

  assign covered  = (l_r <= cur_lo_r) && (cur_hi_r <= r_r);
  assign disjoint = (cur_lo_r > r_r) || (cur_hi_r < l_r);
  assign leaf     = (cur_lo_r == cur_hi_r);

  assign in_l_clip = (in_position_left == '0) ? PosW'(1) : in_position_left;
  assign in_r_clip = (in_position_right > cnt_r) ? cnt_r : in_position_right;
  assign in_empty  = in_l_clip > in_r_clip;
  assign in_l_m1   = in_position_left - PosW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lst_pkg::S_CLR: begin
        if (clr_cnt_r == NodeW'(lst_pkg::NodeDepth - 1)) begin
          state_nxt = clr_sums_r ? lst_pkg::S_IDLE : lst_pkg::S_VISIT;
        end
      end
      lst_pkg::S_IDLE: begin
        if (accept) begin
          unique case (lst_pkg::func_t'(in_func))
            lst_pkg::FUNC_LOAD:  state_nxt = lst_pkg::S_IDLE;
            lst_pkg::FUNC_BUILD: state_nxt = lst_pkg::S_CLR;
            lst_pkg::FUNC_ADD:   state_nxt = in_empty ? lst_pkg::S_IDLE : lst_pkg::S_VISIT;
            lst_pkg::FUNC_SUM:   state_nxt = in_empty ? lst_pkg::S_OUT : lst_pkg::S_VISIT;
            default:             state_nxt = lst_pkg::S_IDLE;
          endcase
        end
      end
      lst_pkg::S_VISIT: begin
        if (func_r == lst_pkg::FUNC_BUILD) begin
          state_nxt = leaf ? lst_pkg::S_BLF : lst_pkg::S_VISIT;
        end else if (covered) begin
          state_nxt = (func_r == lst_pkg::FUNC_SUM) ? lst_pkg::S_ACC : lst_pkg::S_AP0;
        end else if (disjoint) begin
          state_nxt = lst_pkg::S_RET;
        end else begin
          state_nxt = lst_pkg::S_HD0;
        end
      end
      lst_pkg::S_ACC:  state_nxt = lst_pkg::S_RET;
      lst_pkg::S_AP0:  state_nxt = lst_pkg::S_AP1;
      lst_pkg::S_AP1:  state_nxt = lst_pkg::S_RET;
      lst_pkg::S_BLF:  state_nxt = lst_pkg::S_RET;
      lst_pkg::S_HD0:  state_nxt = lst_pkg::S_HD1;
      lst_pkg::S_HD1:  state_nxt = (p_rd == '0) ? lst_pkg::S_VISIT : lst_pkg::S_HD2;
      lst_pkg::S_HD2:  state_nxt = lst_pkg::S_HD3;
      lst_pkg::S_HD3:  state_nxt = lst_pkg::S_HD4;
      lst_pkg::S_HD4:  state_nxt = lst_pkg::S_HD5;
      lst_pkg::S_HD5:  state_nxt = lst_pkg::S_VISIT;
      lst_pkg::S_RET: begin
        if (sp_r == '0) begin
          state_nxt = (func_r == lst_pkg::FUNC_SUM) ? lst_pkg::S_OUT : lst_pkg::S_IDLE;
        end else if (!top.right) begin
          state_nxt = lst_pkg::S_VISIT;
        end else begin
          state_nxt = (func_r == lst_pkg::FUNC_SUM) ? lst_pkg::S_RET : lst_pkg::S_FIN0;
        end
      end
      lst_pkg::S_FIN0: state_nxt = lst_pkg::S_FIN1;
      lst_pkg::S_FIN1: state_nxt = lst_pkg::S_FIN2;
      lst_pkg::S_FIN2: state_nxt = lst_pkg::S_RET;
      lst_pkg::S_OUT:  state_nxt = out_free ? lst_pkg::S_IDLE : lst_pkg::S_OUT;
      default:         state_nxt = lst_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    func_nxt     = func_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_sums_nxt = clr_sums_r;
    cnt_nxt      = cnt_r;
    l_nxt        = l_r;
    r_nxt        = r_r;
    inc_nxt      = inc_r;
    acc_nxt      = acc_r;
    t_nxt        = t_r;
    s_tmp_nxt    = s_tmp_r;
    cur_node_nxt = cur_node_r;
    cur_lo_nxt   = cur_lo_r;
    cur_hi_nxt   = cur_hi_r;
    sp_nxt       = sp_r;
    stk_nxt      = stk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sum_nxt  = out_sum_r;
    descend      = 1'b0;

    s_we = 1'b0;  s_waddr = cur_node_r;  s_wdata = add_y;  s_raddr = cur_node_r;
    p_we = 1'b0;  p_waddr = cur_node_r;  p_wdata = add_y;  p_raddr = cur_node_r;
    e_we = 1'b0;  e_waddr = in_l_m1[lst_pkg::ElemAW-1:0];
    e_raddr = lo_m1[lst_pkg::ElemAW-1:0];
    alu_ctrl.add_a  = acc_r;
    alu_ctrl.add_b  = s_rd;
    alu_ctrl.mul_en = 1'b0;
    alu_ctrl.mul_a  = inc_r;
    alu_ctrl.mul_b  = span;

    if (cfg_valid) begin
      if (cfg_data == '0) begin
        cnt_nxt = PosW'(1);
      end else if (cfg_data > PosW'(lst_pkg::MaxElem)) begin
        cnt_nxt = PosW'(lst_pkg::MaxElem);
      end else begin
        cnt_nxt = cfg_data;
      end
    end

    unique case (state_r)
      lst_pkg::S_CLR: begin
        p_we = 1'b1;  p_waddr = clr_cnt_r;  p_wdata = '0;
        s_we = clr_sums_r;  s_waddr = clr_cnt_r;  s_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + NodeW'(1);
      end
      lst_pkg::S_IDLE: begin
        if (accept) begin
          func_nxt     = lst_pkg::func_t'(in_func);
          l_nxt        = in_l_clip;
          r_nxt        = in_r_clip;
          inc_nxt      = in_value;
          acc_nxt      = '0;
          cur_node_nxt = NodeW'(1);
          cur_lo_nxt   = PosW'(1);
          cur_hi_nxt   = cnt_r;
          sp_nxt       = '0;
          clr_cnt_nxt  = '0;
          clr_sums_nxt = 1'b0;
          e_we = (lst_pkg::func_t'(in_func) == lst_pkg::FUNC_LOAD) &&
                 (in_position_left != '0) &&
                 (in_position_left <= PosW'(lst_pkg::MaxElem));
        end
      end
      lst_pkg::S_VISIT: begin
        if (func_r == lst_pkg::FUNC_BUILD) begin
          descend = !leaf;
        end else if (covered && func_r == lst_pkg::FUNC_ADD) begin
          alu_ctrl.mul_en = 1'b1;
        end
      end
      lst_pkg::S_ACC: begin
        acc_nxt = add_y;
      end
      lst_pkg::S_AP0: begin
        alu_ctrl.add_a = p_rd;
        alu_ctrl.add_b = inc_r;
        p_we = 1'b1;
      end
      lst_pkg::S_AP1: begin
        alu_ctrl.add_a = s_rd;
        alu_ctrl.add_b = prod;
        s_we = 1'b1;
      end
      lst_pkg::S_BLF: begin
        s_we = 1'b1;
        s_wdata = e_rd;
      end
      lst_pkg::S_HD0: begin
      end
      lst_pkg::S_HD1: begin
        // pending tag of this node is now on the read port
        t_nxt = p_rd;
        p_raddr = lnode;
        s_raddr = lnode;
        alu_ctrl.mul_en = 1'b1;
        alu_ctrl.mul_a  = p_rd;
        alu_ctrl.mul_b  = span_l;
        descend = (p_rd == '0);
      end
      lst_pkg::S_HD2: begin
        alu_ctrl.add_a = p_rd;
        alu_ctrl.add_b = t_r;
        p_we = 1'b1;  p_waddr = lnode;
        s_raddr = lnode;
      end
      lst_pkg::S_HD3: begin
        alu_ctrl.add_a = s_rd;
        alu_ctrl.add_b = prod;
        s_we = 1'b1;  s_waddr = lnode;
        s_raddr = rnode;
        p_raddr = rnode;
        alu_ctrl.mul_en = 1'b1;
        alu_ctrl.mul_a  = t_r;
        alu_ctrl.mul_b  = span_r;
      end
      lst_pkg::S_HD4: begin
        alu_ctrl.add_a = p_rd;
        alu_ctrl.add_b = t_r;
        p_we = 1'b1;  p_waddr = rnode;
        s_raddr = rnode;
      end
      lst_pkg::S_HD5: begin
        alu_ctrl.add_a = s_rd;
        alu_ctrl.add_b = prod;
        s_we = 1'b1;  s_waddr = rnode;
        p_we = 1'b1;  p_wdata = '0;
        descend = 1'b1;
      end
      lst_pkg::S_RET: begin
        if (sp_r != '0) begin
          if (!top.right) begin
            stk_nxt[sp_m1].right = 1'b1;
            cur_node_nxt = {top.node[NodeW-2:0], 1'b1};
            cur_lo_nxt   = top_mid + PosW'(1);
            cur_hi_nxt   = top.hi;
          end else begin
            sp_nxt       = sp_m1;
            cur_node_nxt = top.node;
            cur_lo_nxt   = top.lo;
            cur_hi_nxt   = top.hi;
          end
        end
      end
      lst_pkg::S_FIN0: begin
        s_raddr = lnode;
      end
      lst_pkg::S_FIN1: begin
        s_raddr = rnode;
        s_tmp_nxt = s_rd;
      end
      lst_pkg::S_FIN2: begin
        alu_ctrl.add_a = s_tmp_r;
        alu_ctrl.add_b = s_rd;
        s_we = 1'b1;
      end
      lst_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
        end
      end
      default: begin
      end
    endcase

    // push the current node and move to its left child
    if (descend) begin
      stk_nxt[sp_r] = '{node: cur_node_r, lo: cur_lo_r, hi: cur_hi_r, right: 1'b0};
      sp_nxt        = sp_r + SpW'(1);
      cur_node_nxt  = lnode;
      cur_hi_nxt    = mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lst_pkg::S_CLR;
      func_r      <= lst_pkg::FUNC_LOAD;
      clr_cnt_r   <= '0;
      clr_sums_r  <= 1'b1;
      cnt_r       <= PosW'(lst_pkg::MaxElem);
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      func_r      <= func_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_sums_r  <= clr_sums_nxt;
      cnt_r       <= cnt_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    inc_r      <= inc_nxt;
    acc_r      <= acc_nxt;
    t_r        <= t_nxt;
    s_tmp_r    <= s_tmp_nxt;
    cur_node_r <= cur_node_nxt;
    cur_lo_r   <= cur_lo_nxt;
    cur_hi_r   <= cur_hi_nxt;
    stk_r      <= stk_nxt;
    out_sum_r  <= out_sum_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

  lst_alu u_alu (
    .clk   (clk),
    .ctrl  (alu_ctrl),
    .add_y (add_y),
    .prod  (prod)
  );

  lst_ram #(.Width(ValW), .Depth(lst_pkg::NodeDepth)) u_sums (
    .clk (clk), .we (s_we), .waddr (s_waddr), .wdata (s_wdata),
    .raddr (s_raddr), .rdata (s_rd)
  );

  lst_ram #(.Width(ValW), .Depth(lst_pkg::NodeDepth)) u_tags (
    .clk (clk), .we (p_we), .waddr (p_waddr), .wdata (p_wdata),
    .raddr (p_raddr), .rdata (p_rd)
  );

  lst_ram #(.Width(ValW), .Depth(lst_pkg::MaxElem)) u_elems (
    .clk (clk), .we (e_we), .waddr (e_waddr), .wdata (in_value),
    .raddr (e_raddr), .rdata (e_rd)
  );

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SpW'(lst_pkg::StackDepth))
    else $error("walk stack overflow");

  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lst_pkg::S_OUT) |-> (sp_r == '0))
    else $error("sum reported with walk unfinished");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= PosW'(lst_pkg::MaxElem)))
    else $error("element count out of range");

  a_node_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lst_pkg::S_VISIT) |-> (cur_lo_r <= cur_hi_r))
    else $error("visited node has empty span");

endmodule

// File: verif/lazy_segment_tree_range_add_sum_tb.sv
// Testbench for lazy_segment_tree_range_add_sum: random and directed load, build, add and sum
// requests, checked against a lazy segment tree held in a scoreboard. Depends on lst_pkg.
`timescale 1ns / 1ps

module lazy_segment_tree_range_add_sum_tb;

  class seg_scoreboard;
    logic [lst_pkg::ValW-1:0] elems [lst_pkg::MaxElem];
    logic [lst_pkg::ValW-1:0] sums [lst_pkg::NodeDepth];
    logic [lst_pkg::ValW-1:0] tags [lst_pkg::NodeDepth];
    int unsigned count_now;
    logic [lst_pkg::ValW-1:0] sum_q [$];
    int errors;
    int checked;
    int requests;

    function new();
      foreach (elems[i]) elems[i] = '0;
      foreach (sums[i]) sums[i] = '0;
      foreach (tags[i]) tags[i] = '0;
      count_now = lst_pkg::MaxElem;
      errors = 0;
      checked = 0;
      requests = 0;
    endfunction

    function void set_count(int unsigned raw);
      if (raw < 1) count_now = 1;
      else if (raw > lst_pkg::MaxElem) count_now = lst_pkg::MaxElem;
      else count_now = raw;
    endfunction

    function void put_tag(int unsigned node, int unsigned span,
                          logic [lst_pkg::ValW-1:0] inc);
      logic [lst_pkg::ValW-1:0] span64;
      if (node >= lst_pkg::NodeDepth) return;
      span64 = span;
      tags[node] += inc;
      sums[node] += span64 * inc;
    endfunction

    function void push_down(int unsigned node, int unsigned lo, int unsigned hi);
      int unsigned mid;
      logic [lst_pkg::ValW-1:0] t;
      if (node >= lst_pkg::NodeDepth) return;
      mid = (lo + hi) >> 1;
      t = tags[node];
      put_tag(2 * node, mid - lo + 1, t);
      put_tag(2 * node + 1, hi - mid, t);
      tags[node] = '0;
    endfunction

    function logic [lst_pkg::ValW-1:0] kids_total(int unsigned node);
      logic [lst_pkg::ValW-1:0] s;
      s = '0;
      if (2 * node < lst_pkg::NodeDepth) s += sums[2 * node];
      if (2 * node + 1 < lst_pkg::NodeDepth) s += sums[2 * node + 1];
      return s;
    endfunction

    function void build_tree(int unsigned node, int unsigned lo, int unsigned hi);
      int unsigned mid;
      if (node >= lst_pkg::NodeDepth) return;
      if (lo == hi) begin
        sums[node] = (lo >= 1 && lo <= lst_pkg::MaxElem) ? elems[lo - 1] : '0;
        return;
      end
      mid = (lo + hi) >> 1;
      build_tree(2 * node, lo, mid);
      build_tree(2 * node + 1, mid + 1, hi);
      sums[node] = kids_total(node);
    endfunction

    function void add_range(int unsigned node, int unsigned lo, int unsigned hi,
                            int unsigned l, int unsigned r, logic [lst_pkg::ValW-1:0] inc);
      int unsigned mid;
      if (node >= lst_pkg::NodeDepth) return;
      if (l <= lo && hi <= r) begin
        put_tag(node, hi - lo + 1, inc);
      end else if (!(lo > r || hi < l)) begin
        mid = (lo + hi) >> 1;
        push_down(node, lo, hi);
        add_range(2 * node, lo, mid, l, r, inc);
        add_range(2 * node + 1, mid + 1, hi, l, r, inc);
        sums[node] = kids_total(node);
      end
    endfunction

    function logic [lst_pkg::ValW-1:0] sum_range(int unsigned node, int unsigned lo,
                                                 int unsigned hi, int unsigned l,
                                                 int unsigned r);
      int unsigned mid;
      if (node >= lst_pkg::NodeDepth) return '0;
      if (l <= lo && hi <= r) return sums[node];
      if (lo > r || hi < l) return '0;
      mid = (lo + hi) >> 1;
      push_down(node, lo, hi);
      return sum_range(2 * node, lo, mid, l, r) + sum_range(2 * node + 1, mid + 1, hi, l, r);
    endfunction

    function void note_request(lst_pkg::func_t f, int unsigned l, int unsigned r,
                               logic [lst_pkg::ValW-1:0] v);
      requests++;
      case (f)
        lst_pkg::FUNC_LOAD: begin
          if (l >= 1 && l <= lst_pkg::MaxElem) elems[l - 1] = v;
        end
        lst_pkg::FUNC_BUILD: begin
          foreach (tags[i]) tags[i] = '0;
          build_tree(1, 1, count_now);
        end
        default: begin
          if (l < 1) l = 1;
          if (r > count_now) r = count_now;
          if (f == lst_pkg::FUNC_ADD) begin
            if (l <= r) add_range(1, 1, count_now, l, r, v);
          end else begin
            sum_q.push_back((l <= r) ? sum_range(1, 1, count_now, l, r) : '0);
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_sum(logic [lst_pkg::ValW-1:0] got);
      logic [lst_pkg::ValW-1:0] want;
      if (sum_q.size() == 0) begin
        report($sformatf("unexpected range_sum %h", got));
      end else begin
        want = sum_q.pop_front();
        checked++;
        if (got !== want) report($sformatf("range_sum got %h want %h", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_func;
  logic [lst_pkg::PosW-1:0] in_position_left;
  logic [lst_pkg::PosW-1:0] in_position_right;
  logic signed [lst_pkg::ValW-1:0] in_value;
  logic out_valid;
  logic out_stall;
  logic signed [lst_pkg::ValW-1:0] out_range_sum;
  logic cfg_valid;
  logic cfg_ready;
  logic [lst_pkg::PosW-1:0] cfg_data;

  seg_scoreboard sb = new();
  bit loaded [lst_pkg::MaxElem + 1];
  int burst_left;
  int unsigned cyc;

  lazy_segment_tree_range_add_sum u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_position_left(in_position_left), .in_position_right(in_position_right),
    .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_range_sum(out_range_sum),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: checks each sum it takes; the stall pattern changes over the run.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n && out_valid && !out_stall) sb.check_sum(out_range_sum);
    case ((cyc >> 9) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      2: out_stall <= (cyc[5:0] < 40);
      default: out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task send(lst_pkg::func_t f, int unsigned l, int unsigned r,
            logic [lst_pkg::ValW-1:0] v);
    in_valid <= 1'b1;
    in_func <= f;
    in_position_left <= l[lst_pkg::PosW-1:0];
    in_position_right <= r[lst_pkg::PosW-1:0];
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(f, l[lst_pkg::PosW-1:0], r[lst_pkg::PosW-1:0], v);
    if (f == lst_pkg::FUNC_LOAD && l >= 1 && l <= lst_pkg::MaxElem) loaded[l] = 1'b1;
    // close the burst and idle for a while
    if (--burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 400) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // Hold off until every sum is back and any silent walk has finished, then write.
  task write_count(int unsigned raw);
    in_valid <= 1'b0;
    while (sb.sum_q.size() != 0) @(posedge clk);
    repeat (20000) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= raw[lst_pkg::PosW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_count(raw[lst_pkg::PosW-1:0]);
  endtask

  function logic [lst_pkg::ValW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return {32'hffff_ffff, $urandom} | 64'h8000_0000_0000_0000;
      2: return 64'h7fff_ffff_ffff_ffff - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function int unsigned rand_pos();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2047);
    return $urandom_range(0, sb.count_now + 1);
  endfunction

  function int unsigned first_unloaded();
    for (int i = 1; i <= sb.count_now; i++) if (!loaded[i]) return i;
    return 0;
  endfunction

  task random_phase(int n, bit allow_build);
    int pick;
    int unsigned gap_pos;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      gap_pos = first_unloaded();
      if (pick < 15) begin
        send(lst_pkg::FUNC_LOAD, (gap_pos != 0 && pick < 8) ? gap_pos : rand_pos(),
             rand_pos(), rand_value());
      end else if (pick < 22 && allow_build) begin
        // build reads every element up to the count: fill gaps first
        if (gap_pos != 0) begin
          send(lst_pkg::FUNC_LOAD, gap_pos, $urandom_range(0, 2047), rand_value());
        end else begin
          send(lst_pkg::FUNC_BUILD, rand_pos(), rand_pos(), rand_value());
        end
      end else if (pick < 58) begin
        send(lst_pkg::FUNC_ADD, rand_pos(), rand_pos(), rand_value());
      end else begin
        send(lst_pkg::FUNC_SUM, rand_pos(), rand_pos(), rand_value());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_position_left = '0;
    in_position_right = '0;
    in_value = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cyc = 0;
    burst_left = 4;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, ignored loads, clipping, empty intervals
    send(lst_pkg::FUNC_SUM, 1, 1024, 64'd0);
    write_count(8);
    send(lst_pkg::FUNC_LOAD, 1, 2047, 64'h7fff_ffff_ffff_ffff);
    send(lst_pkg::FUNC_LOAD, 2, 0, 64'h8000_0000_0000_0000);
    send(lst_pkg::FUNC_LOAD, 3, 0, 64'hffff_ffff_ffff_ffff);
    send(lst_pkg::FUNC_LOAD, 4, 0, 64'd0);
    for (int p = 5; p <= 8; p++) send(lst_pkg::FUNC_LOAD, p, 0, 64'd100 * p);
    send(lst_pkg::FUNC_LOAD, 0, 0, 64'd55);
    send(lst_pkg::FUNC_LOAD, 2047, 0, 64'd66);
    send(lst_pkg::FUNC_LOAD, 1024, 0, 64'd77);
    send(lst_pkg::FUNC_SUM, 1, 8, 64'd0);
    send(lst_pkg::FUNC_BUILD, 2047, 2047, 64'hffff_ffff_ffff_ffff);
    send(lst_pkg::FUNC_SUM, 0, 2047, 64'd0);
    send(lst_pkg::FUNC_ADD, 1, 8, 64'h7fff_ffff_ffff_ffff);
    send(lst_pkg::FUNC_SUM, 6, 3, 64'd0);
    send(lst_pkg::FUNC_ADD, 9, 20, 64'd5);
    send(lst_pkg::FUNC_ADD, 5, 2, 64'd5);
    send(lst_pkg::FUNC_SUM, 9, 2047, 64'd0);
    send(lst_pkg::FUNC_ADD, 3, 3, 64'h8000_0000_0000_0000);
    send(lst_pkg::FUNC_SUM, 3, 3, 64'd0);
    send(lst_pkg::FUNC_SUM, 2, 7, 64'd0);
    send(lst_pkg::FUNC_SUM, 1, 8, 64'd0);

    random_phase(150, 1'b1);
    write_count(1);
    random_phase(80, 1'b1);
    write_count(0);
    random_phase(60, 1'b1);
    write_count(2);
    random_phase(90, 1'b1);
    write_count(37);
    random_phase(150, 1'b1);
    write_count(16);
    random_phase(120, 1'b1);
    // top of the range over a stale tree; no build since most elements are unloaded
    write_count(2047);
    random_phase(60, 1'b0);
    write_count(1024);
    random_phase(60, 1'b0);
    write_count(200);
    random_phase(380, 1'b1);

    in_valid <= 1'b0;
    while (sb.sum_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("Run covered %0d requests over ten element counts, 1 to 1024, %0d sums checked.",
             sb.requests, sb.checked);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
